// ----- hdl/cfv_pkg.sv -----
// shared types, constants and helpers for the carrier frame validator
`default_nettype none
package cfv_pkg;

  localparam int LENGTH_BITS  = 32;
  localparam int HEADER_BYTES = 56;
  localparam int CNT_W        = LENGTH_BITS;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_MAGIC    = 4'd2,
    ST_PHASH    = 4'd3,
    ST_COUNT    = 4'd4,
    ST_PAGE     = 4'd5,
    ST_FRAME    = 4'd6,
    ST_LENGTH   = 4'd7,
    ST_OFFSET   = 4'd8,
    ST_MAPPED   = 4'd9,
    ST_RANGE    = 4'd10,
    ST_PLHASH   = 4'd11,
    ST_TOO_LONG = 4'd12
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [3:0] status;
    logic       is_last;
  } out_item_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             last_byte;
    logic             in_payload;
    logic             too_long;
    logic [CNT_W:0]   len;
  } work_t;

  // magic text byte by position (little-endian "NUISPFD1")
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h4e;
      3'd1: c = 8'h55;
      3'd2: c = 8'h49;
      3'd3: c = 8'h53;
      3'd4: c = 8'h50;
      3'd5: c = 8'h46;
      3'd6: c = 8'h44;
      default: c = 8'h31;
    endcase
    return c;
  endfunction

  // fnv-1a step: xor then multiply by 2^40 + 2^8 + 0xb3 as shift-add
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/cfv_front.sv -----
// front end: byte counter, header capture and payload window classification
`default_nettype none
module cfv_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [31:0]               exp_length,
  input  wire cfv_pkg::in_item_t         in_item,
  input  wire logic                      take,
  output cfv_pkg::work_t                 work,
  output logic                           magic_ok,
  output logic [31:0]                    frame_total,
  output logic [31:0]                    page_bytes,
  output logic [31:0]                    frame_number,
  output logic [63:0]                    payload_start,
  output logic [63:0]                    payload_size,
  output logic [63:0]                    mapped_size,
  output logic [63:0]                    payload_hash_field
);
  import cfv_pkg::*;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  logic [CNT_W-1:0] byte_count;
  logic             overflow;
  logic [64:0]      rel;
  logic [5:0]       hidx;
  logic             in_hdr;

  assign in_hdr = byte_count < CNT_W'(HEADER_BYTES);
  assign hidx   = byte_count[5:0];
  assign rel    = {{(65-CNT_W){1'b0}}, byte_count} - {1'b0, payload_start};

  // classification of the current byte
  always_comb begin
    work.data_byte  = in_item.data_byte;
    work.last_byte  = in_item.last_byte;
    work.in_payload = !overflow && !in_hdr && !rel[64] && (rel[63:0] < {32'd0, exp_length});
    work.too_long   = overflow || (byte_count == COUNT_MAX);
    work.len        = work.too_long ? {1'b0, COUNT_MAX}
                                    : {1'b0, byte_count} + (CNT_W+1)'(1);
  end

  // counter and header fields
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      overflow   <= 1'b0;
      magic_ok   <= 1'b1;
      frame_total <= '0; page_bytes <= '0; frame_number <= '0;
      payload_start <= '0; payload_size <= '0; mapped_size <= '0;
      payload_hash_field <= '0;
    end else if (take) begin
      if (in_item.last_byte) begin
        byte_count <= '0;
        overflow   <= 1'b0;
        magic_ok   <= 1'b1;
        frame_total <= '0; page_bytes <= '0; frame_number <= '0;
        payload_start <= '0; payload_size <= '0; mapped_size <= '0;
        payload_hash_field <= '0;
      end else begin
        if (byte_count == COUNT_MAX) overflow <= 1'b1;
        else byte_count <= byte_count + CNT_W'(1);
        if (in_hdr) begin
          if (hidx < 6'd8) begin
            if (in_item.data_byte != magic_char(hidx[2:0])) magic_ok <= 1'b0;
          end else if (hidx < 6'd12) frame_total[8*(hidx-6'd8) +: 8] <= in_item.data_byte;
          else if (hidx < 6'd16) page_bytes[8*(hidx-6'd12) +: 8] <= in_item.data_byte;
          else if (hidx < 6'd20) frame_number[8*(hidx-6'd16) +: 8] <= in_item.data_byte;
          else if (hidx < 6'd24) begin
          end else if (hidx < 6'd32) payload_start[8*(hidx-6'd24) +: 8] <= in_item.data_byte;
          else if (hidx < 6'd40) payload_size[8*(hidx-6'd32) +: 8] <= in_item.data_byte;
          else if (hidx < 6'd48) mapped_size[8*(hidx-6'd40) +: 8] <= in_item.data_byte;
          else payload_hash_field[8*(hidx-6'd48) +: 8] <= in_item.data_byte;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cfv_back.sv -----
// back end: running hashes, verdict checks and output register
`default_nettype none
module cfv_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [31:0]          exp_frame,
  input  wire logic [63:0]          exp_phash,
  input  wire logic [31:0]          exp_length,
  input  wire cfv_pkg::work_t       work,
  input  wire logic                 magic_ok,
  input  wire logic [31:0]          frame_total,
  input  wire logic [31:0]          page_bytes,
  input  wire logic [31:0]          frame_number,
  input  wire logic [63:0]          payload_start,
  input  wire logic [63:0]          payload_size,
  input  wire logic [63:0]          mapped_size,
  input  wire logic [63:0]          payload_hash_field,
  input  wire logic                 take,
  output cfv_pkg::out_item_t        res_a,
  output logic                      res_a_valid,
  output cfv_pkg::out_item_t        res_b,
  output logic                      res_b_valid
);
  import cfv_pkg::*;

  logic [63:0] whole_hash, payload_hash_run, ph_next, pl_next;
  logic [63:0] mask, len64, plfield;
  status_t     st;

  assign ph_next = fnv_step(whole_hash, work.data_byte);
  assign pl_next = work.in_payload ? fnv_step(payload_hash_run, work.data_byte)
                                   : payload_hash_run;
  assign mask  = {32'd0, page_bytes - 32'd1};
  assign len64 = {{(63-CNT_W){1'b0}}, work.len};
  // a header-only packet ends on the top byte of the hash field
  assign plfield = (len64 == 64'(HEADER_BYTES)) ?
                   {work.data_byte, payload_hash_field[55:0]} : payload_hash_field;

  // first failing check
  always_comb begin
    if (work.too_long) st = ST_TOO_LONG;
    else if (len64 < 64'(HEADER_BYTES)) st = ST_SHORT;
    else if (!magic_ok) st = ST_MAGIC;
    else if (ph_next != exp_phash) st = ST_PHASH;
    else if (frame_total != 32'd1) st = ST_COUNT;
    else if (page_bytes == 32'd0 || (page_bytes & mask[31:0]) != 32'd0) st = ST_PAGE;
    else if (frame_number != exp_frame) st = ST_FRAME;
    else if (payload_size != {32'd0, exp_length}) st = ST_LENGTH;
    else if (payload_start < 64'(HEADER_BYTES) || (payload_start & mask) != 64'd0)
      st = ST_OFFSET;
    else if ((mapped_size & mask) != 64'd0 || mapped_size < {32'd0, exp_length})
      st = ST_MAPPED;
    else if (payload_start > len64 || mapped_size > len64 - payload_start) st = ST_RANGE;
    else if (pl_next != plfield) st = ST_PLHASH;
    else st = ST_OK;
  end

  // hashes and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      whole_hash       <= FNV_BASIS;
      payload_hash_run <= FNV_BASIS;
      res_a_valid      <= 1'b0;
      res_b_valid      <= 1'b0;
    end else begin
      res_a_valid <= take && work.in_payload;
      res_b_valid <= take && work.last_byte;
      if (take) begin
        whole_hash       <= work.last_byte ? FNV_BASIS : ph_next;
        payload_hash_run <= work.last_byte ? FNV_BASIS : pl_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_a <= '{kind: 1'b0, payload_byte: work.data_byte, status: ST_OK, is_last: 1'b0};
    res_b <= '{kind: 1'b1, payload_byte: 8'd0, status: st, is_last: 1'b1};
  end

endmodule
`default_nettype wire

// ----- hdl/cfv_queue.sv -----
// result queue between the engine and the output channel
`default_nettype none
module cfv_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfv_pkg::out_item_t   res_a,
  input  wire logic                 res_a_valid,
  input  wire cfv_pkg::out_item_t   res_b,
  input  wire logic                 res_b_valid,
  output logic                      room,
  output cfv_pkg::out_item_t        out_item,
  output logic                      out_valid,
  input  wire logic                 out_stall
);
  import cfv_pkg::*;

  out_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              pop;
  logic [1:0]        pushes;

  assign out_valid = fill != '0;
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign pushes    = {1'b0, res_a_valid} + {1'b0, res_b_valid};
  // room for two more results beside the stored and in-flight ones
  assign room      = (fill + (QPTR_W+1)'(pushes)) <= (QPTR_W+1)'(QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; fill <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(pushes);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      fill <= fill + (QPTR_W+1)'(pushes) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_a_valid) mem[wr_ptr] <= res_a;
    if (res_b_valid) mem[res_a_valid ? wr_ptr + QPTR_W'(1) : wr_ptr] <= res_b;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("result queue overflow");
  a_empty_no_pop: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> !pop) else $error("pop from empty queue");
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_b_valid |-> $past(room)) else $error("push without room");

endmodule
`default_nettype wire

// ----- hdl/carrier_frame_validator.sv -----
// Carrier frame validator top level.
// A result passes through the back end result register, then the result queue,
// before it is offered.
// Throughput: one byte per cycle while the output side drains and in_stall is low;
// set by the combinational shift-add FNV step in the back end.
// Input stalls when stored plus in-flight results leave no room for two more
// in the four-entry queue: when a byte's two results go into a non-empty queue, or on output stalls.
// Reset (rst, synchronous): configuration registers zero, packet state cleared, queue empty.
`default_nettype none
module carrier_frame_validator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [cfv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cfv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire cfv_pkg::in_item_t             in_item,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  output cfv_pkg::out_item_t                 out_item,
  output logic                               out_valid,
  input  wire logic                          out_stall
);
  import cfv_pkg::*;

  logic [31:0] exp_frame, exp_length;
  logic [63:0] exp_phash;
  logic        take, room;
  work_t       work;
  logic        magic_ok;
  logic [31:0] frame_total, page_bytes, frame_number;
  logic [63:0] payload_start, payload_size, mapped_size, payload_hash_field;
  out_item_t   res_a, res_b;
  logic        res_a_valid, res_b_valid;

  assign in_stall = !room;
  assign take     = in_valid && room;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_frame <= '0; exp_phash <= '0; exp_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME:  exp_frame  <= cfg_data[31:0];
        REG_PHASH:  exp_phash  <= cfg_data;
        REG_LENGTH: exp_length <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cfv_front u_front (
    .clk, .rst, .exp_length, .in_item, .take, .work, .magic_ok, .frame_total,
    .page_bytes, .frame_number, .payload_start, .payload_size, .mapped_size,
    .payload_hash_field
  );

  cfv_back u_back (
    .clk, .rst, .exp_frame, .exp_phash, .exp_length, .work, .magic_ok,
    .frame_total, .page_bytes, .frame_number, .payload_start, .payload_size,
    .mapped_size, .payload_hash_field, .take, .res_a, .res_a_valid, .res_b,
    .res_b_valid
  );

  cfv_queue u_queue (
    .clk, .rst, .res_a, .res_a_valid, .res_b, .res_b_valid, .room, .out_item,
    .out_valid, .out_stall
  );

endmodule
`default_nettype wire

// ----- verif/tb_carrier_frame_validator.sv -----
// self-checking testbench for the carrier frame validator
`timescale 1ns / 1ps
`default_nettype none
module tb_carrier_frame_validator;
  import cfv_pkg::*;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [63:0] MAGIC_LE = 64'h3144465053495_54e;
  localparam logic [63:0] FNV_PRIME_C = 64'h100000001b3;
  localparam logic [63:0] FNV_START = 64'hcbf29ce484222325;

  // fault classes used to build packets
  localparam int F_NONE = 0, F_SHORT = 1, F_MAGIC = 2, F_PHASH = 3, F_COUNT = 4;
  localparam int F_PAGE = 5, F_FRAME = 6, F_LENGTH = 7, F_OFFSET = 8, F_MAPPED = 9;
  localparam int F_RANGE = 10, F_PLHASH = 11, F_NOISE = 12;

  // predictor of the validator plus the queue of results it has not yet seen
  class frame_scoreboard;
    logic [31:0] want_frame, want_len;
    logic [63:0] want_phash;
    logic [31:0] count;
    logic        overflow;
    logic [63:0] run_hash, win_hash, start, size, mapped, win_field;
    logic [31:0] total, page, frame;
    logic        magic_good;
    out_item_t   awaited[$];
    int          mismatches;

    function new();
      want_frame = '0; want_len = '0; want_phash = '0; mismatches = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      count = '0; overflow = 1'b0;
      run_hash = FNV_START; win_hash = FNV_START; magic_good = 1'b1;
      total = '0; page = '0; frame = '0;
      start = '0; size = '0; mapped = '0; win_field = '0;
    endfunction

    function logic [63:0] fnv(input logic [63:0] h, input logic [7:0] b);
      return (h ^ {56'd0, b}) * FNV_PRIME_C;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
      case (idx)
        REG_FRAME:  want_frame = d[31:0];
        REG_PHASH:  want_phash = d;
        REG_LENGTH: want_len = d[31:0];
        default: ;
      endcase
    endfunction

    // first failing check: too long first, then in status order
    function status_t verdict(input logic too_long, input logic [63:0] len);
      logic [63:0] mask;
      mask = {32'd0, page} - 64'd1;
      if (too_long) return ST_TOO_LONG;
      if (len < HEADER_BYTES) return ST_SHORT;
      if (!magic_good) return ST_MAGIC;
      if (run_hash != want_phash) return ST_PHASH;
      if (total != 32'd1) return ST_COUNT;
      if (page == 0 || ({32'd0, page} & mask) != 0) return ST_PAGE;
      if (frame != want_frame) return ST_FRAME;
      if (size != {32'd0, want_len}) return ST_LENGTH;
      if (start < HEADER_BYTES || (start & mask) != 0) return ST_OFFSET;
      if ((mapped & mask) != 0 || mapped < {32'd0, want_len}) return ST_MAPPED;
      if (start > len || mapped > len - start) return ST_RANGE;
      if (win_hash != win_field) return ST_PLHASH;
      return ST_OK;
    endfunction

    function void note_byte(input in_item_t it);
      logic [63:0] i;
      logic [63:0] v;
      logic        long_pkt;
      out_item_t r;
      i = {32'd0, count};
      v = {56'd0, it.data_byte};
      run_hash = fnv(run_hash, it.data_byte);
      if (i < 8) begin
        if (it.data_byte != MAGIC_LE[8*i[2:0] +: 8]) magic_good = 1'b0;
      end else if (i < 12) total |= v[31:0] << (8 * (i - 8));
      else if (i < 16) page |= v[31:0] << (8 * (i - 12));
      else if (i < 20) frame |= v[31:0] << (8 * (i - 16));
      else if (i < 24) ;
      else if (i < 32) start |= v << (8 * (i - 24));
      else if (i < 40) size |= v << (8 * (i - 32));
      else if (i < 48) mapped |= v << (8 * (i - 40));
      else if (i < 56) win_field |= v << (8 * (i - 48));
      // payload window byte goes out tentatively
      if (!overflow && i >= HEADER_BYTES && i >= start && i - start < {32'd0, want_len}) begin
        win_hash = fnv(win_hash, it.data_byte);
        r.kind = KIND_PAYLOAD; r.payload_byte = it.data_byte; r.status = ST_OK;
        r.is_last = 1'b0;
        awaited.push_back(r);
      end
      if (it.last_byte) begin
        long_pkt = overflow || (count == '1);
        r.kind = KIND_VERDICT; r.payload_byte = '0;
        r.status = verdict(long_pkt, long_pkt ? {32'd0, 32'hffffffff} : i + 1);
        r.is_last = 1'b1;
        awaited.push_back(r);
        clear_packet();
      end else if (count == '1) begin
        overflow = 1'b1;
      end else begin
        count = count + 1;
      end
    endfunction

    function void check_out(input out_item_t got);
      out_item_t w;
      string exp_s, got_s;
      got_s = $sformatf("kind %0d byte %h status %0d last %0d",
                        got.kind, got.payload_byte, got.status, got.is_last);
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %s", got_s);
        return;
      end
      w = awaited.pop_front();
      if (got.kind !== w.kind || got.payload_byte !== w.payload_byte ||
          got.status !== w.status || got.is_last !== w.is_last) begin
        mismatches++;
        exp_s = $sformatf("kind %0d byte %h status %0d last %0d",
                          w.kind, w.payload_byte, w.status, w.is_last);
        if (mismatches <= 10) $display("mismatch: expected %s, got %s", exp_s, got_s);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  in_item_t in_item = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  out_item_t out_item;
  logic out_valid;
  logic out_stall = 1'b0;

  frame_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;

  logic [7:0]  pkt[$];
  logic [31:0] next_frame, next_len;
  logic [63:0] next_phash;

  carrier_frame_validator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_item(in_item), .in_valid(in_valid), .in_stall(in_stall),
    .out_item(out_item), .out_valid(out_valid), .out_stall(out_stall)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_carrier_frame_validator failed");
    $finish;
  end

  // result side: check accepted results and stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_out(out_item);
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    cfg_we <= 1'b0;
  endtask

  // wait for the block to drain
  task automatic wait_drained();
    int n;
    in_valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < 100000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall);
    sb.note_byte('{data_byte: b, last_byte: last});
    bytes_sent++;
  endtask

  task automatic put_le(input int pos, input logic [63:0] v, input int n);
    for (int k = 0; k < n; k++) pkt[pos + k] = v[8*k +: 8];
  endtask

  // build one packet with a chosen fault, and the register values to go with it
  task automatic build_packet(input int fault, input logic [31:0] frame_in,
                              input logic [31:0] len_in);
    logic [31:0] pg, cnt, frm;
    logic [63:0] off, map, lenf, wh, h;
    int total_len, cut;
    next_frame = frame_in; next_len = len_in;
    pg = 32'd1 << $urandom_range(0, 3);
    off = ((56 + pg - 1) / pg) * pg + pg * $urandom_range(0, 1);
    map = ((len_in + pg - 1) / pg) * pg + pg * $urandom_range(0, 1);
    cnt = 32'd1; frm = frame_in; lenf = {32'd0, len_in};
    case (fault)
      F_COUNT: cnt = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom() | 32'd2;
      F_PAGE: pg = ($urandom_range(0, 1) != 0) ? 32'd0 : 32'd3 << $urandom_range(0, 3);
      F_FRAME: frm = frame_in ^ (32'd1 << $urandom_range(0, 31));
      F_LENGTH: lenf = lenf + 64'd1 + $urandom_range(0, 3);
      F_OFFSET: off = (pg > 1) ? off + 1 : 64'($urandom_range(0, 55));
      F_MAPPED: map = (pg > 1) ? map + 1 : ((len_in > 0) ? {32'd0, len_in} - 1 : map);
      default: ;
    endcase
    total_len = int'(off) + int'(map) + $urandom_range(0, 4);
    if (total_len < 56) total_len = 56 + $urandom_range(0, 4);
    if (fault == F_RANGE) map = map + 64'(pg) * 64'(total_len);
    pkt.delete();
    for (int k = 0; k < total_len; k++) pkt.push_back(8'($urandom()));
    put_le(0, MAGIC_LE, 8);
    if (fault == F_MAGIC) pkt[$urandom_range(0, 7)] ^= 8'd1 << $urandom_range(0, 7);
    put_le(8, cnt, 4); put_le(12, pg, 4); put_le(16, frm, 4);
    put_le(24, off, 8); put_le(32, lenf, 8); put_le(40, map, 8);
    wh = FNV_START;
    for (int k = 56; k < total_len; k++)
      if (k >= off && k - off < len_in) wh = sb.fnv(wh, pkt[k]);
    if (fault == F_PLHASH) wh ^= 64'd1 << $urandom_range(0, 63);
    put_le(48, wh, 8);
    if (fault == F_SHORT) begin
      cut = $urandom_range(1, 55);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    h = FNV_START;
    foreach (pkt[k]) h = sb.fnv(h, pkt[k]);
    next_phash = (fault == F_PHASH) ? h ^ (64'd1 << $urandom_range(0, 63)) : h;
  endtask

  // raw random bytes with random or extreme register values
  task automatic build_noise();
    int n;
    next_frame = ($urandom_range(0, 2) == 0) ? '1 : $urandom();
    next_len = ($urandom_range(0, 2) == 0) ? '1 : 32'($urandom_range(0, 40));
    next_phash = ($urandom_range(0, 1) != 0) ? 64'd0 : '1;
    n = $urandom_range(1, 90);
    pkt.delete();
    for (int k = 0; k < n; k++) pkt.push_back(8'($urandom()));
  endtask

  task automatic run_packet(input logic reconfig);
    if (reconfig) begin
      wait_drained();
      write_reg(REG_FRAME, {32'd0, next_frame});
      write_reg(REG_PHASH, next_phash);
      write_reg(REG_LENGTH, {32'd0, next_len});
    end
    foreach (pkt[k]) send_byte(pkt[k], k == pkt.size() - 1);
  endtask

  task automatic random_phase(input int sp, input int rp, input int nbytes);
    int f, stop;
    send_idle_pct = sp; recv_idle_pct = rp;
    stop = bytes_sent + nbytes;
    while (bytes_sent < stop) begin
      f = $urandom_range(0, 19);
      if (f > F_NOISE) f = F_NONE;
      if (f == F_NOISE) build_noise();
      else build_packet(f, $urandom(), 32'($urandom_range(0, 24)));
      run_packet($urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // unknown index is ignored
    write_reg(REG_UNUSED, '1);
    // directed: one packet per verdict except too long, then register extremes
    for (int f = F_NONE; f <= F_PLHASH; f++) begin
      build_packet(f, $urandom(), 32'($urandom_range(1, 12)));
      run_packet(1'b1);
    end
    build_packet(F_NONE, '1, 32'd0);
    run_packet(1'b1);
    build_noise();
    next_len = '1;
    run_packet(1'b1);
    // random traffic under three idling patterns
    random_phase(31, 52, 80);
    random_phase(52, 31, 80);
    random_phase(0, 0, 80);
    in_valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < 200000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() == 0 && sb.mismatches == 0) begin
      $display("tb_carrier_frame_validator passed");
    end else begin
      $display("tb_carrier_frame_validator failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/cfv_pkg.sv
hdl/cfv_front.sv
hdl/cfv_back.sv
hdl/cfv_queue.sv
hdl/carrier_frame_validator.sv
verif/tb_carrier_frame_validator.sv
